// ===== hw/rtl/elru_pkg.sv =====
// Shared types and constants for the exact LRU replacement tracker.
package elru_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 6;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef enum logic {
    KIND_REF   = 1'b0,
    KIND_EVICT = 1'b1
  } kind_e;

  // Broadcast to every cell for the item being executed.
  typedef struct packed {
    logic   ref_en;
    logic   evict_en;
    frame_t frame;
  } cell_cmd_t;

  // Handed from one cell to the next older cell.
  typedef struct packed {
    frame_t frame;
    logic   valid;
    logic   found;
    frame_t victim;
  } cell_link_t;

endpackage

// ===== hw/rtl/elru_cell.sv =====
// One recency slot of the LRU stack: holds a frame and passes it to its older neighbor.
module elru_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  elru_pkg::cell_cmd_t  cmd_i,
  input  elru_pkg::cell_link_t link_i,
  input  logic                next_valid_i,
  output elru_pkg::cell_link_t link_o
);
  import elru_pkg::*;

  logic   valid_q, valid_d;
  frame_t frame_q, frame_d;
  logic   match;
  logic   is_last;
  logic   shift_en;

  assign match    = valid_q && (frame_q == cmd_i.frame);
  assign is_last  = valid_q && !next_valid_i;
  // Take the newer neighbor's entry unless the referenced frame sits above.
  assign shift_en = cmd_i.ref_en && !link_i.found;

  always_comb begin
    valid_d = valid_q;
    frame_d = frame_q;
    if (shift_en) begin
      valid_d = link_i.valid;
      frame_d = link_i.frame;
    end else if (cmd_i.evict_en && is_last) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign link_o.frame  = frame_q;
  assign link_o.valid  = valid_q;
  assign link_o.found  = link_i.found || match;
  assign link_o.victim = link_i.victim | (is_last ? frame_q : '0);

endmodule

// ===== hw/rtl/exact_lru_replacement_tracker.sv =====
// Top level of the exact LRU replacement tracker: item register, cell row, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries kind_i and frame_number_i.
//   A reference item (kind 0) moves the frame to the most recent end of the
//   order, inserting it if absent; a frame number at or above the frame count
//   is dropped. A reference gives no result. An evict item (kind 1) removes
//   the least recent frame and gives one result on the output channel
//   (out_valid_o / out_stall_i): victim_frame_o, or list_empty_o = 1 with a
//   zero victim when nothing is tracked.
//   The order lives in a row of NUM_FRAMES cells, most recent first; every
//   item updates all cells together, each cell taking its newer neighbor's
//   entry or holding, and an evict clears the tail cell. Throughput is one
//   item per cycle while no evict is held back; the search for the
//   referenced frame ripples along the cell row and sets the cycle time.
//   An evict runs from the item register and loads the result register.
//   While the result register is full and stalled, a waiting evict holds in
//   the item register and the input stalls; references still pass.
//   Reset empties the order at once and drops any pending item or result.
module exact_lru_replacement_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  elru_pkg::frame_t      frame_number_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output elru_pkg::frame_t      victim_frame_o,
  output logic                  list_empty_o
);
  import elru_pkg::*;

  // Item register
  logic   item_valid_q, item_valid_d;
  logic   item_kind_q;
  frame_t item_frame_q;
  logic   in_accept;
  logic   exec;
  logic   is_evict;
  logic   ref_ok;

  // Result register
  logic   out_valid_q, out_valid_d;
  frame_t out_victim_q;
  logic   out_empty_q;

  cell_cmd_t                  cmd;
  cell_link_t [NUM_FRAMES:0]  link;
  logic [NUM_FRAMES-1:0]      valid_vec;
  logic [NUM_FRAMES-1:0]      last_vec;

  assign is_evict = (item_kind_q == KIND_EVICT);
  assign ref_ok   = (item_kind_q == KIND_REF) && (int'(item_frame_q) < NUM_FRAMES);
  // An evict runs only when the result register is free or draining now.
  assign exec       = item_valid_q && (!is_evict || !out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !exec;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign item_valid_d = in_accept || (item_valid_q && !exec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_kind_q  <= kind_i;
      item_frame_q <= frame_number_i;
    end
  end

  // Broadcast command; the new frame enters at the head of the row.
  assign cmd.ref_en   = exec && ref_ok;
  assign cmd.evict_en = exec && is_evict;
  assign cmd.frame    = item_frame_q;

  assign link[0].frame  = item_frame_q;
  assign link[0].valid  = 1'b1;
  assign link[0].found  = 1'b0;
  assign link[0].victim = '0;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    logic next_valid;
    if (i == NUM_FRAMES - 1) begin : g_end
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_valid = link[i+2].valid;
    end

    elru_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .link_i       (link[i]),
      .next_valid_i (next_valid),
      .link_o       (link[i+1])
    );

    assign valid_vec[i] = link[i+1].valid;
    assign last_vec[i]  = link[i+1].valid && !next_valid;
  end

  // Load the result on an executed evict; drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.evict_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.evict_en) begin
      out_victim_q <= link[NUM_FRAMES].victim;
      out_empty_q  <= !link[1].valid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign victim_frame_o = out_victim_q;
  assign list_empty_o   = out_empty_q;

  // Tracked frames always fill the row from the head without gaps.
  a_single_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(last_vec))
    else $error("more than one tail cell in the LRU row");

  a_head_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ref_en |=> valid_vec[0] && (link[1].frame == $past(item_frame_q)))
    else $error("referenced frame did not land at the head");

  a_evict_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.evict_en |=> out_valid_q)
    else $error("executed evict gave no result");

  a_evict_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.evict_en && valid_vec[0] |=>
      $countones(valid_vec) == $countones($past(valid_vec)) - 1)
    else $error("evict did not remove exactly one frame");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid_q && is_evict && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked evict");

endmodule

// ===== tb/sv/exact_lru_replacement_tracker_tb.sv =====
// Self-checking testbench for the exact LRU replacement tracker: directed table, then random items.
`timescale 1ns / 100ps

module exact_lru_replacement_tracker_tb;
  import elru_pkg::*;

  // Link values are one bit wider than a frame number so that the null link fits.
  typedef logic [FRAME_W:0] link_t;
  localparam link_t LINK_NIL = link_t'(NUM_FRAMES);

  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_LIMIT  = 4000;   // cycles allowed for the last results to come out
  localparam int TAIL_CYCLES  = 8;      // extra cycles waited after the expected results have drained

  // One evict result as the output channel carries it.
  typedef struct packed {
    frame_t victim;
    logic   empty;
  } evict_result_t;

  // One row of the directed table; hand_checked marks a row whose result is typed in.
  typedef struct packed {
    kind_e         kind;
    frame_t        frame;
    logic          hand_checked;
    evict_result_t result;
  } stim_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  logic   kind_i;
  logic   [5:0] frame_number_i;
  logic   out_valid_o;
  logic   out_stall_i;
  logic   [5:0] victim_frame_o;
  logic   list_empty_o;

  exact_lru_replacement_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .victim_frame_o (victim_frame_o),
    .list_empty_o   (list_empty_o)
  );

  // Recency order as a doubly linked list: newer_link points toward the most
  // recent end, older_link toward the least recent end.
  link_t newer_link [NUM_FRAMES];
  link_t older_link [NUM_FRAMES];
  link_t mru_ptr;
  link_t lru_ptr;

  evict_result_t victims_due [$];
  stim_row_t     directed_rows [$];
  evict_result_t seen_result;
  evict_result_t due_result;

  int mismatch_count;
  int items_sent;
  int send_idle_pct;
  int recv_stall_pct;

  // Free-running clock, 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Print one line per mismatch and count it; quiet down after the first few dozen.
  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  function automatic void clear_order();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      newer_link[i] = LINK_NIL;
      older_link[i] = LINK_NIL;
    end
    mru_ptr = LINK_NIL;
    lru_ptr = LINK_NIL;
  endfunction

  // Cut a tracked frame out of the list and splice its neighbors together.
  function automatic void unlink_frame(input link_t f);
    link_t nw;
    link_t od;
    nw = newer_link[f];
    od = older_link[f];
    if (nw != LINK_NIL) older_link[nw] = od;
    else                mru_ptr = od;
    if (od != LINK_NIL) newer_link[od] = nw;
    else                lru_ptr = nw;
    newer_link[f] = LINK_NIL;
    older_link[f] = LINK_NIL;
  endfunction

  // Apply one accepted item to the recency order; return 1 when it yields a result.
  function automatic bit advance_recency(input kind_e k, input frame_t f,
                                         output evict_result_t res);
    link_t fx;
    fx  = link_t'(f);
    res = '0;
    if (k == KIND_REF) begin
      // Drop out-of-range frames; leave the order alone when f is already newest.
      if (int'(f) >= NUM_FRAMES || mru_ptr == fx)
        return 1'b0;
      if (newer_link[fx] != LINK_NIL || older_link[fx] != LINK_NIL)
        unlink_frame(fx);
      newer_link[fx] = LINK_NIL;
      older_link[fx] = mru_ptr;
      if (mru_ptr != LINK_NIL) newer_link[mru_ptr] = fx;
      else                     lru_ptr = fx;
      mru_ptr = fx;
      return 1'b0;
    end
    // Evict: report an empty list, or remove the least recent frame.
    if (lru_ptr == LINK_NIL) begin
      res.empty = 1'b1;
      return 1'b1;
    end
    res.victim = lru_ptr[FRAME_W-1:0];
    unlink_frame(lru_ptr);
    return 1'b1;
  endfunction

  // Pick the idling of both sides from how far the run has come:
  // no idling, then sender gaps, then receiver stalls, then both.
  function automatic void pick_idling();
    case ((items_sent * 4) / (RANDOM_ITEMS + 25))
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endfunction

  // Offer one item, starting and ending at a falling edge. Hold the payload
  // steady while stalled; on acceptance, advance the predicted order and
  // queue the expected result, taking the typed-in one where given.
  task automatic offer_item(input kind_e k, input frame_t f,
                            input logic hand_checked, input evict_result_t typed);
    evict_result_t res;
    pick_idling();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      kind_i     <= 1'($urandom_range(0, 1));
      frame_number_i <= frame_t'($urandom_range(0, 63));
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    frame_number_i <= f;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (advance_recency(k, f, res))
      victims_due.push_back(hand_checked ? typed : res);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_row(input kind_e k, input frame_t f,
                         input logic hand_checked, input frame_t v, input logic e);
    stim_row_t row;
    row.kind          = k;
    row.frame         = f;
    row.hand_checked  = hand_checked;
    row.result.victim = v;
    row.result.empty  = e;
    directed_rows.push_back(row);
  endtask

  // Receiver: stall at the falling edge with the current phase's odds.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Checker: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen_result.victim = victim_frame_o;
      seen_result.empty  = list_empty_o;
      if (victims_due.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: victim %0d empty %0b",
                                victim_frame_o, list_empty_o));
      end else begin
        due_result = victims_due.pop_front();
        if (seen_result.victim !== due_result.victim)
          note_mismatch($sformatf("victim_frame %0d, expected %0d",
                                  victim_frame_o, due_result.victim));
        if (seen_result.empty !== due_result.empty)
          note_mismatch($sformatf("list_empty %0b, expected %0b",
                                  list_empty_o, due_result.empty));
      end
    end
  end

  // Main sequence: reset, directed table, random bursts, drain, verdict.
  initial begin
    frame_t perm [NUM_FRAMES];
    frame_t tmp;
    int     j;
    int     burst;
    int     len;
    int     evict_pct;
    int     waited;

    in_valid_i     = 1'b0;
    kind_i         = KIND_REF;
    frame_number_i = '0;
    rst_ni         = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clear_order();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: empty evicts, a single frame, both extremes, re-reference
    // of the newest frame, moves from the tail and the middle, drain to empty.
    add_row(KIND_EVICT, 6'd0,  1'b1, 6'd0,  1'b1);   // evict from an empty list
    add_row(KIND_REF,   6'd0,  1'b0, 6'd0,  1'b0);
    add_row(KIND_EVICT, 6'd0,  1'b1, 6'd0,  1'b0);   // lone frame comes back out
    add_row(KIND_EVICT, 6'd63, 1'b1, 6'd0,  1'b1);   // frame field ignored on evict
    add_row(KIND_REF,   6'd63, 1'b0, 6'd0,  1'b0);
    add_row(KIND_REF,   6'd0,  1'b0, 6'd0,  1'b0);
    add_row(KIND_REF,   6'd63, 1'b0, 6'd0,  1'b0);   // tail moves to head
    add_row(KIND_REF,   6'd63, 1'b0, 6'd0,  1'b0);   // already newest: no change
    add_row(KIND_EVICT, 6'd0,  1'b1, 6'd0,  1'b0);
    add_row(KIND_EVICT, 6'd0,  1'b1, 6'd63, 1'b0);
    add_row(KIND_EVICT, 6'd21, 1'b1, 6'd0,  1'b1);
    add_row(KIND_REF,   6'd42, 1'b0, 6'd0,  1'b0);
    add_row(KIND_REF,   6'd21, 1'b0, 6'd0,  1'b0);
    add_row(KIND_REF,   6'd7,  1'b0, 6'd0,  1'b0);
    add_row(KIND_REF,   6'd42, 1'b0, 6'd0,  1'b0);   // from the tail
    add_row(KIND_REF,   6'd7,  1'b0, 6'd0,  1'b0);   // from the middle
    add_row(KIND_REF,   6'd7,  1'b0, 6'd0,  1'b0);
    add_row(KIND_EVICT, 6'd0,  1'b0, 6'd0,  1'b0);
    add_row(KIND_REF,   6'd21, 1'b0, 6'd0,  1'b0);   // re-insert after eviction
    add_row(KIND_EVICT, 6'd42, 1'b0, 6'd0,  1'b0);
    add_row(KIND_EVICT, 6'd0,  1'b0, 6'd0,  1'b0);
    add_row(KIND_EVICT, 6'd0,  1'b0, 6'd0,  1'b0);
    add_row(KIND_EVICT, 6'd0,  1'b1, 6'd0,  1'b1);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].kind, directed_rows[i].frame,
                 directed_rows[i].hand_checked, directed_rows[i].result);

    // Random bursts until the item budget is spent.
    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      burst = $urandom_range(0, 99);
      if (burst < 25) begin
        // Fill: reference every frame in shuffled order, stir, then drain to empty and sometimes past it.
        for (int i = 0; i < NUM_FRAMES; i++) perm[i] = frame_t'(i);
        for (int i = NUM_FRAMES - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < NUM_FRAMES; i++)
          offer_item(KIND_REF, perm[i], 1'b0, '0);
        len = $urandom_range(0, 16);
        for (int i = 0; i < len; i++)
          offer_item(KIND_REF, frame_t'($urandom_range(0, 63)), 1'b0, '0);
        len = NUM_FRAMES + $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
          offer_item(KIND_EVICT, frame_t'($urandom_range(0, 63)), 1'b0, '0);
      end else begin
        // Short burst: hot small pool, uniform frames, or evict-heavy noise.
        len       = $urandom_range(8, 40);
        evict_pct = (burst < 65) ? 30 : (burst < 85) ? 50 : 80;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < evict_pct)
            offer_item(KIND_EVICT, frame_t'($urandom_range(0, 63)), 1'b0, '0);
          else if (burst < 65)
            offer_item(KIND_REF,
                       frame_t'(($urandom_range(0, 3) == 0) ? $urandom_range(56, 63)
                                                            : $urandom_range(0, 7)),
                       1'b0, '0);
          else
            offer_item(KIND_REF, frame_t'($urandom_range(0, 63)), 1'b0, '0);
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for the outstanding results, then wait out TAIL_CYCLES.
    waited = 0;
    while (victims_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (victims_due.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", victims_due.size()));

    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
